[sv/kps2_pkg.sv]
// package: shared types, constants and the scan code lookup for the set 2 translator
package kps2_pkg;

  // usage code of the escape key
  localparam logic [7:0] USAGE_ESC  = 8'd41;
  // fixed prefix bytes
  localparam logic [7:0] BYTE_EXT   = 8'hE0;
  localparam logic [7:0] BYTE_BREAK = 8'hF0;
  localparam logic [7:0] BYTE_PAUSE = 8'hE1;
  // index of the final byte of the pause run
  localparam logic [2:0] PAUSE_LAST = 3'd7;

  typedef enum logic {
    CMD_KEY,
    CMD_PAUSE
  } cmd_kind_e;

  // one queued command for the byte sequencer
  typedef struct packed {
    cmd_kind_e  kind;
    logic       ext;
    logic       brk;
    logic [7:0] code;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic       ext;
    logic [7:0] code;
  } code_entry_t;

  // usage code to set 2 code, zero code means unmapped
  function automatic code_entry_t lookup_code(input logic [7:0] usage);
    code_entry_t e;
    e = '{ext: 1'b0, code: 8'h00};
    case (usage)
      8'd4:   e.code = 8'h1c;
      8'd5:   e.code = 8'h32;
      8'd6:   e.code = 8'h21;
      8'd7:   e.code = 8'h23;
      8'd8:   e.code = 8'h24;
      8'd9:   e.code = 8'h2b;
      8'd10:  e.code = 8'h34;
      8'd11:  e.code = 8'h33;
      8'd12:  e.code = 8'h43;
      8'd13:  e.code = 8'h3b;
      8'd14:  e.code = 8'h42;
      8'd15:  e.code = 8'h4b;
      8'd16:  e.code = 8'h3a;
      8'd17:  e.code = 8'h31;
      8'd18:  e.code = 8'h44;
      8'd19:  e.code = 8'h4d;
      8'd20:  e.code = 8'h15;
      8'd21:  e.code = 8'h2d;
      8'd22:  e.code = 8'h1b;
      8'd23:  e.code = 8'h2c;
      8'd24:  e.code = 8'h3c;
      8'd25:  e.code = 8'h2a;
      8'd26:  e.code = 8'h1d;
      8'd27:  e.code = 8'h22;
      8'd28:  e.code = 8'h35;
      8'd29:  e.code = 8'h1a;
      8'd30:  e.code = 8'h16;
      8'd31:  e.code = 8'h1e;
      8'd32:  e.code = 8'h26;
      8'd33:  e.code = 8'h25;
      8'd34:  e.code = 8'h2e;
      8'd35:  e.code = 8'h36;
      8'd36:  e.code = 8'h3d;
      8'd37:  e.code = 8'h3e;
      8'd38:  e.code = 8'h46;
      8'd39:  e.code = 8'h45;
      8'd40:  e.code = 8'h5a;
      8'd41:  e.code = 8'h76;
      8'd42:  e.code = 8'h66;
      8'd43:  e.code = 8'h0d;
      8'd44:  e.code = 8'h29;
      8'd45:  e.code = 8'h4e;
      8'd46:  e.code = 8'h55;
      8'd47:  e.code = 8'h54;
      8'd48:  e.code = 8'h5b;
      8'd49:  e.code = 8'h5d;
      8'd51:  e.code = 8'h4c;
      8'd52:  e.code = 8'h52;
      8'd53:  e.code = 8'h0e;
      8'd54:  e.code = 8'h41;
      8'd55:  e.code = 8'h49;
      8'd56:  e.code = 8'h4a;
      8'd58:  e.code = 8'h05;
      8'd59:  e.code = 8'h06;
      8'd60:  e.code = 8'h04;
      8'd61:  e.code = 8'h0c;
      8'd62:  e.code = 8'h03;
      8'd63:  e.code = 8'h0b;
      8'd64:  e.code = 8'h83;
      8'd65:  e.code = 8'h0a;
      8'd66:  e.code = 8'h01;
      8'd67:  e.code = 8'h09;
      8'd68:  e.code = 8'h78;
      8'd69:  e.code = 8'h07;
      8'd74:  e = '{ext: 1'b1, code: 8'h6c};
      8'd79:  e = '{ext: 1'b1, code: 8'h74};
      8'd80:  e = '{ext: 1'b1, code: 8'h6b};
      8'd81:  e = '{ext: 1'b1, code: 8'h72};
      8'd82:  e = '{ext: 1'b1, code: 8'h75};
      8'd84:  e = '{ext: 1'b1, code: 8'h4a};
      8'd85:  e.code = 8'h7c;
      8'd86:  e.code = 8'h7b;
      8'd87:  e.code = 8'h79;
      8'd88:  e = '{ext: 1'b1, code: 8'h5a};
      8'd89:  e.code = 8'h69;
      8'd90:  e.code = 8'h72;
      8'd91:  e.code = 8'h7a;
      8'd92:  e.code = 8'h6b;
      8'd93:  e.code = 8'h73;
      8'd94:  e.code = 8'h74;
      8'd95:  e.code = 8'h6c;
      8'd96:  e.code = 8'h75;
      8'd97:  e.code = 8'h7d;
      8'd98:  e.code = 8'h70;
      8'd99:  e.code = 8'h71;
      8'd100: e.code = 8'h61;
      8'd224: e.code = 8'h14;
      8'd225: e.code = 8'h12;
      8'd226: e.code = 8'h11;
      8'd228: e = '{ext: 1'b1, code: 8'h14};
      8'd229: e.code = 8'h59;
      8'd230: e = '{ext: 1'b1, code: 8'h11};
      default: e = '{ext: 1'b0, code: 8'h00};
    endcase
    return e;
  endfunction

  // pause/break run, E1 14 77 E1 F0 14 F0 77
  function automatic logic [7:0] pause_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = BYTE_PAUSE;
      3'd1:    b = 8'h14;
      3'd2:    b = 8'h77;
      3'd3:    b = BYTE_PAUSE;
      3'd4:    b = BYTE_BREAK;
      3'd5:    b = 8'h14;
      3'd6:    b = BYTE_BREAK;
      default: b = 8'h77;
    endcase
    return b;
  endfunction

endpackage

[sv/kps2_front.sv]
// front end: accepts key events, looks up the code and pushes a command
module kps2_front (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     pressed_i,
  input  logic [7:0]               key_usage_i,
  input  logic                     escape_sends_pause_i,
  input  kps2_pkg::queue_status_t  q_status_i,
  output logic                     push_o,
  output kps2_pkg::cmd_t           push_cmd_o
);

  kps2_pkg::code_entry_t entry;
  logic                  is_pause;
  logic                  emits;

  always_comb begin
    entry    = kps2_pkg::lookup_code(key_usage_i);
    is_pause = escape_sends_pause_i && (key_usage_i == kps2_pkg::USAGE_ESC);
    // pause release and unmapped keys give no bytes
    emits    = is_pause ? pressed_i : (entry.code != 8'h00);
    push_cmd_o.kind = is_pause ? kps2_pkg::CMD_PAUSE : kps2_pkg::CMD_KEY;
    push_cmd_o.ext  = entry.ext;
    push_cmd_o.brk  = ~pressed_i;
    push_cmd_o.code = entry.code;
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full && emits;

endmodule

[sv/kps2_queue.sv]
// command queue between front end and byte sequencer
module kps2_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  kps2_pkg::cmd_t           push_cmd_i,
  input  logic                     pop_i,
  output kps2_pkg::cmd_t           head_cmd_o,
  output kps2_pkg::queue_status_t  status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  kps2_pkg::cmd_t entries_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign do_push = push_i && (count_q != CNT_FULL);
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_cmd_o     = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNT_FULL);
  assign status_o.empty = (count_q == '0);

endmodule

[sv/kps2_back.sv]
// byte sequencer: walks each command and drives the output register
module kps2_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kps2_pkg::queue_status_t  q_status_i,
  input  kps2_pkg::cmd_t           head_cmd_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               scan_byte_o,
  output logic                     last_byte_o
);

  logic           busy_q, busy_d;
  kps2_pkg::cmd_t cmd_q, cmd_d;
  logic [2:0]     idx_q, idx_d;
  logic           ovalid_q, ovalid_d;
  logic [7:0]     obyte_q, obyte_d;
  logic           olast_q, olast_d;

  kps2_pkg::cmd_t cur;
  logic [2:0]     cur_idx;
  logic [1:0]     key_last;
  logic [7:0]     cur_byte;
  logic           cur_last;
  logic           have, advance;

  always_comb begin
    cur      = busy_q ? cmd_q : head_cmd_i;
    cur_idx  = busy_q ? idx_q : 3'd0;
    key_last = {1'b0, cur.ext} + {1'b0, cur.brk};
    if (cur.kind == kps2_pkg::CMD_PAUSE) begin
      cur_byte = kps2_pkg::pause_byte(cur_idx);
      cur_last = (cur_idx == kps2_pkg::PAUSE_LAST);
    end else begin
      // prefix, break, then code
      if (cur.ext && cur_idx == 3'd0) begin
        cur_byte = kps2_pkg::BYTE_EXT;
      end else if (cur.brk && cur_idx == {2'b00, cur.ext}) begin
        cur_byte = kps2_pkg::BYTE_BREAK;
      end else begin
        cur_byte = cur.code;
      end
      cur_last = (cur_idx == {1'b0, key_last});
    end
  end

  assign have    = busy_q || !q_status_i.empty;
  assign advance = have && (!ovalid_q || !out_stall_i);
  assign pop_o   = advance && !busy_q;

  always_comb begin
    busy_d   = busy_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q && out_stall_i;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (advance) begin
      ovalid_d = 1'b1;
      obyte_d  = cur_byte;
      olast_d  = cur_last;
      cmd_d    = cur;
      idx_d    = cur_idx + 3'd1;
      busy_d   = !cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign scan_byte_o = obyte_q;
  assign last_byte_o = olast_q;

endmodule

[sv/key_event_to_ps2_set2_bytes.sv]
// top level: key event to ps/2 set 2 byte run translator
//
// input channel: one item is a key event (pressed_i, key_usage_i), taken at a
//   clock edge where in_valid_i is high and in_stall_o is low
// output channel: one item is one byte (scan_byte_o, last_byte_o), taken at an
//   edge where out_valid_o is high and out_stall_i is low; last_byte_o marks
//   the final byte of the run for one key event
// config: cfg_we_i writes cfg_wdata_i into escape_sends_pause (reset 1); write
//   only while the block is idle
// the front end classifies each event and drops unmapped keys and pause
//   releases; commands sit in a QUEUE_DEPTH entry queue for the sequencer
// a taken event is queued first; its first byte then goes to the output register
// throughput: while out_stall_i is low, the sequencer emits one byte per cycle with
//   no gap between runs; an event gives 1 to 3 bytes (e0 prefix, f0 break, code)
//   or 8 bytes for the pause run; the single output byte register sets that rate
// input is taken while the queue has room, even when output is stalled
// out_stall_i holds the output register; the queue then fills and in_stall_o
//   rises once it is full
// reset clears the queue, sequencer and output valid, and sets
//   escape_sends_pause to 1
module key_event_to_ps2_set2_bytes #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       pressed_i,
  input  logic [7:0] key_usage_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] scan_byte_o,
  output logic       last_byte_o
);

  // config register
  logic esc_pause_q, esc_pause_d;

  // front to queue
  logic           push;
  kps2_pkg::cmd_t push_cmd;

  // queue to back
  logic                    pop;
  kps2_pkg::cmd_t          head_cmd;
  kps2_pkg::queue_status_t q_status;

  assign esc_pause_d = cfg_we_i ? cfg_wdata_i : esc_pause_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pause_q <= 1'b1;
    end else begin
      esc_pause_q <= esc_pause_d;
    end
  end

  kps2_front u_front (
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .pressed_i            (pressed_i),
    .key_usage_i          (key_usage_i),
    .escape_sends_pause_i (esc_pause_q),
    .q_status_i           (q_status),
    .push_o               (push),
    .push_cmd_o           (push_cmd)
  );

  kps2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .status_o   (q_status)
  );

  kps2_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_cmd_i  (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scan_byte_o (scan_byte_o),
    .last_byte_o (last_byte_o)
  );

  // queue can never be both full and empty
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue status inconsistent");

  // a taken pause press always leaves a command behind
  a_pause_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && pressed_i && esc_pause_q &&
     key_usage_i == kps2_pkg::USAGE_ESC) |=> !q_status.empty)
    else $error("pause press not queued");

  // the last byte of a run is never a prefix byte
  a_last_not_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_byte_o) |->
      (scan_byte_o != kps2_pkg::BYTE_EXT && scan_byte_o != kps2_pkg::BYTE_BREAK &&
       scan_byte_o != kps2_pkg::BYTE_PAUSE))
    else $error("run ends on a prefix byte");

  // pop only when the queue holds a command
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

[tb/tb_key_event_to_ps2_set2_bytes.sv]
// testbench for the key event to ps/2 set 2 byte run translator
module tb_key_event_to_ps2_set2_bytes;
  timeunit 1ns;
  timeprecision 1ps;

  // receiver hold-off used to fill the command queue and stall the input
  localparam int LONG_HOLD_CYCLES = 60;
  // quiet cycles before a config write, covers events that make no bytes
  localparam int DRAIN_CYCLES     = 8;
  // cycles after the last expected byte before the verdict
  localparam int TAIL_CYCLES      = 16;
  // cycles with no handshake on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT   = 1000;

  // pause/break run as seen on the wire
  localparam logic [7:0] PAUSE_SEQ [8] = '{
    kps2_pkg::BYTE_PAUSE, 8'h14, 8'h77, kps2_pkg::BYTE_PAUSE,
    kps2_pkg::BYTE_BREAK, 8'h14, kps2_pkg::BYTE_BREAK, 8'h77};

  // one byte on the output channel
  typedef struct packed {
    logic [7:0] scan_byte;
    logic       last_byte;
  } ps2_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       pressed_i;
  logic [7:0] key_usage_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] scan_byte_o;
  logic       last_byte_o;

  // bytes still owed by the block, oldest first
  ps2_byte_t  expected_bytes[$];
  // usages that have a set 2 code, used to bias the random keys
  logic [7:0] mapped_keys[$];
  // our copy of escape_sends_pause
  logic       esc_is_pause;
  // random idling on both channels
  bit         idling_on;
  // number of long hold-offs asked of the receiver
  int         hold_requests;
  int         error_count = 0;
  int         quiet_cycles = 0;

  key_event_to_ps2_set2_bytes u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pressed_i   (pressed_i),
    .key_usage_i (key_usage_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scan_byte_o (scan_byte_o),
    .last_byte_o (last_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // set 2 code and extended flag for a usage, code zero when unmapped
  function automatic kps2_pkg::code_entry_t set2_entry(input logic [7:0] usage);
    kps2_pkg::code_entry_t e;
    e.ext  = 1'b0;
    e.code = 8'h00;
    case (usage)
      // letters
      8'd4:  e.code = 8'h1c;  8'd5:  e.code = 8'h32;  8'd6:  e.code = 8'h21;
      8'd7:  e.code = 8'h23;  8'd8:  e.code = 8'h24;  8'd9:  e.code = 8'h2b;
      8'd10: e.code = 8'h34;  8'd11: e.code = 8'h33;  8'd12: e.code = 8'h43;
      8'd13: e.code = 8'h3b;  8'd14: e.code = 8'h42;  8'd15: e.code = 8'h4b;
      8'd16: e.code = 8'h3a;  8'd17: e.code = 8'h31;  8'd18: e.code = 8'h44;
      8'd19: e.code = 8'h4d;  8'd20: e.code = 8'h15;  8'd21: e.code = 8'h2d;
      8'd22: e.code = 8'h1b;  8'd23: e.code = 8'h2c;  8'd24: e.code = 8'h3c;
      8'd25: e.code = 8'h2a;  8'd26: e.code = 8'h1d;  8'd27: e.code = 8'h22;
      8'd28: e.code = 8'h35;  8'd29: e.code = 8'h1a;
      // digit row, enter, esc, backspace, tab, space, punctuation
      8'd30: e.code = 8'h16;  8'd31: e.code = 8'h1e;  8'd32: e.code = 8'h26;
      8'd33: e.code = 8'h25;  8'd34: e.code = 8'h2e;  8'd35: e.code = 8'h36;
      8'd36: e.code = 8'h3d;  8'd37: e.code = 8'h3e;  8'd38: e.code = 8'h46;
      8'd39: e.code = 8'h45;  8'd40: e.code = 8'h5a;  8'd41: e.code = 8'h76;
      8'd42: e.code = 8'h66;  8'd43: e.code = 8'h0d;  8'd44: e.code = 8'h29;
      8'd45: e.code = 8'h4e;  8'd46: e.code = 8'h55;  8'd47: e.code = 8'h54;
      8'd48: e.code = 8'h5b;  8'd49: e.code = 8'h5d;  8'd51: e.code = 8'h4c;
      8'd52: e.code = 8'h52;  8'd53: e.code = 8'h0e;  8'd54: e.code = 8'h41;
      8'd55: e.code = 8'h49;  8'd56: e.code = 8'h4a;
      // function keys
      8'd58: e.code = 8'h05;  8'd59: e.code = 8'h06;  8'd60: e.code = 8'h04;
      8'd61: e.code = 8'h0c;  8'd62: e.code = 8'h03;  8'd63: e.code = 8'h0b;
      8'd64: e.code = 8'h83;  8'd65: e.code = 8'h0a;  8'd66: e.code = 8'h01;
      8'd67: e.code = 8'h09;  8'd68: e.code = 8'h78;  8'd69: e.code = 8'h07;
      // navigation cluster, all extended
      8'd74: e.code = 8'h6c;  8'd79: e.code = 8'h74;  8'd80: e.code = 8'h6b;
      8'd81: e.code = 8'h72;  8'd82: e.code = 8'h75;
      // keypad
      8'd84: e.code = 8'h4a;  8'd85: e.code = 8'h7c;  8'd86: e.code = 8'h7b;
      8'd87: e.code = 8'h79;  8'd88: e.code = 8'h5a;  8'd89: e.code = 8'h69;
      8'd90: e.code = 8'h72;  8'd91: e.code = 8'h7a;  8'd92: e.code = 8'h6b;
      8'd93: e.code = 8'h73;  8'd94: e.code = 8'h74;  8'd95: e.code = 8'h6c;
      8'd96: e.code = 8'h75;  8'd97: e.code = 8'h7d;  8'd98: e.code = 8'h70;
      8'd99: e.code = 8'h71;  8'd100: e.code = 8'h61;
      // modifiers
      8'd224: e.code = 8'h14;  8'd225: e.code = 8'h12;  8'd226: e.code = 8'h11;
      8'd228: e.code = 8'h14;  8'd229: e.code = 8'h59;  8'd230: e.code = 8'h11;
      default: e.code = 8'h00;
    endcase
    case (usage)
      8'd74, 8'd79, 8'd80, 8'd81, 8'd82, 8'd84, 8'd88, 8'd228, 8'd230: e.ext = 1'b1;
      default: e.ext = 1'b0;
    endcase
    return e;
  endfunction

  function automatic void expect_byte(input logic [7:0] b, input logic last);
    ps2_byte_t nb;
    nb.scan_byte = b;
    nb.last_byte = last;
    expected_bytes.push_back(nb);
  endfunction

  // byte run that one accepted key event should produce
  function automatic void expand_key_event(input logic make, input logic [7:0] usage);
    kps2_pkg::code_entry_t entry;
    // esc as pause: eight bytes on press, nothing on release
    if (usage == kps2_pkg::USAGE_ESC && esc_is_pause) begin
      if (make) begin
        for (int i = 0; i < 8; i++) expect_byte(PAUSE_SEQ[i], i == 7);
      end
      return;
    end
    entry = set2_entry(usage);
    // unmapped usage makes no bytes
    if (entry.code == 8'h00) return;
    if (entry.ext) expect_byte(kps2_pkg::BYTE_EXT, 1'b0);
    if (!make) expect_byte(kps2_pkg::BYTE_BREAK, 1'b0);
    expect_byte(entry.code, 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch at %0t: %s, got %0h want %0h", $time, what, got, want);
  endtask

  // offer one key event and wait until it is taken, valid stays up for a
  // following event unless a gap is drawn
  task automatic send_key_event(input logic make, input logic [7:0] usage);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pressed_i   <= make;
    key_usage_i <= usage;
    do @(posedge clk_i); while (in_stall_o);
    expand_key_event(make, usage);
  endtask

  // register write once every owed byte is out and the front end is quiet
  task automatic set_escape_mode(input logic pause_on);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pause_on;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    esc_is_pause = pause_on;
  endtask

  // table extremes, extended keys, unmapped usages, esc as pause at reset value
  task automatic test_directed_keys();
    send_key_event(1'b1, 8'd4);
    send_key_event(1'b0, 8'd4);
    send_key_event(1'b1, 8'd74);
    send_key_event(1'b0, 8'd74);
    send_key_event(1'b0, 8'd230);
    send_key_event(1'b1, 8'd228);
    send_key_event(1'b1, 8'd0);
    send_key_event(1'b0, 8'd255);
    send_key_event(1'b1, 8'd50);
    send_key_event(1'b1, 8'd100);
    send_key_event(1'b0, 8'd64);
    send_key_event(1'b1, kps2_pkg::USAGE_ESC);
    send_key_event(1'b0, kps2_pkg::USAGE_ESC);
    send_key_event(1'b1, 8'd224);
    send_key_event(1'b0, 8'd84);
  endtask

  // esc toggles between its own code and the pause run
  task automatic test_escape_modes();
    set_escape_mode(1'b0);
    send_key_event(1'b1, kps2_pkg::USAGE_ESC);
    send_key_event(1'b0, kps2_pkg::USAGE_ESC);
    send_key_event(1'b1, 8'd170);
    set_escape_mode(1'b1);
    send_key_event(1'b0, kps2_pkg::USAGE_ESC);
    send_key_event(1'b1, kps2_pkg::USAGE_ESC);
  endtask

  // long receiver hold-off while events keep coming, queue fills, input stalls
  task automatic test_backpressure();
    idling_on = 1'b0;
    hold_requests++;
    repeat (16) begin
      if ($urandom_range(0, 3) == 0) send_key_event(1'b1, kps2_pkg::USAGE_ESC);
      else send_key_event(1'($urandom_range(0, 1)),
                          mapped_keys[$urandom_range(0, mapped_keys.size() - 1)]);
    end
    idling_on = 1'b1;
  endtask

  // mostly mapped keys, some esc and some raw usages across the whole range
  task automatic test_random_events(input int count);
    int pick;
    logic [7:0] usage;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) usage = mapped_keys[$urandom_range(0, mapped_keys.size() - 1)];
      else if (pick == 7) usage = kps2_pkg::USAGE_ESC;
      else usage = 8'($urandom_range(0, 255));
      send_key_event(1'($urandom_range(0, 1)), usage);
    end
  endtask

  // receiver: random stall bursts, or one long hold-off on request
  initial begin : drive_receiver
    int stall_left;
    int holds_served;
    stall_left   = 0;
    holds_served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (hold_requests != holds_served) begin
          stall_left = LONG_HOLD_CYCLES;
          holds_served++;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 9);
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // every byte taken is matched against the oldest owed byte
  always @(posedge clk_i) begin : check_bytes
    ps2_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with none owed", scan_byte_o, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (scan_byte_o !== want.scan_byte)
          report_mismatch("scan_byte", scan_byte_o, want.scan_byte);
        if (last_byte_o !== want.last_byte)
          report_mismatch("last_byte", last_byte_o, want.last_byte);
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("key_event_to_ps2_set2_bytes regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    kps2_pkg::code_entry_t e;
    idling_on     = 1'b1;
    hold_requests = 0;
    esc_is_pause  = 1'b1;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    pressed_i   <= 1'b0;
    key_usage_i <= 8'h00;
    for (int u = 0; u < 256; u++) begin
      e = set2_entry(8'(u));
      if (e.code != 8'h00) mapped_keys.push_back(8'(u));
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_keys();
    test_escape_modes();
    test_backpressure();
    test_random_events(55);
    set_escape_mode(1'b0);
    test_random_events(55);
    set_escape_mode(1'b1);
    // a stretch with no idling on either side
    idling_on = 1'b0;
    test_random_events(20);
    idling_on = 1'b1;
    set_escape_mode(1'b0);
    // closing part runs flat out
    idling_on = 1'b0;
    test_random_events(45);

    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      report_mismatch("bytes never sent", expected_bytes.size(), 0);
    if (error_count == 0) begin
      $display("key_event_to_ps2_set2_bytes regression: pass");
    end else begin
      $display("key_event_to_ps2_set2_bytes regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
sv/kps2_pkg.sv
sv/kps2_front.sv
sv/kps2_queue.sv
sv/kps2_back.sv
sv/key_event_to_ps2_set2_bytes.sv
tb/tb_key_event_to_ps2_set2_bytes.sv
